[rtl/assert_macros.svh]
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SVBD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SVBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/svbd_pkg.sv]
// Types, constants and the quarter-wave sine helper for the bulge deformer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package svbd_pkg;

    localparam logic [1:0] CFG_ENERGY    = 2'd0;
    localparam logic [1:0] CFG_BUMP_GAIN = 2'd1;
    localparam logic [1:0] CFG_PHASE_A   = 2'd2;
    localparam logic [1:0] CFG_PHASE_B   = 2'd3;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_VERTEX = 1'b1;

    localparam logic signed [34:0] DOT_THRESH = 35'sd80530637;
    localparam logic [15:0] INV_07_Q15 = 16'd46811;
    localparam logic [11:0] WOB_Q15    = 12'd2294;
    localparam logic [14:0] K14_Q14    = 15'd22938;
    localparam logic [15:0] CAP_MULT   = 16'd52429;
    localparam logic [15:0] ONE_Q15    = 16'd32768;
    localparam logic [13:0] BASE_Q15   = 14'd14746;
    localparam logic [9:0]  BREATH_Q15 = 10'd983;
    localparam logic [13:0] CS_X       = 14'd9127;
    localparam logic [13:0] CS_Y       = 14'd5737;
    localparam logic [13:0] CS_Z       = 14'd7823;
    localparam logic [15:0] QUARTER    = 16'd16384;

    localparam logic [14:0] QUARTER_SINE [17] = '{
        15'd0, 15'd3212, 15'd6393, 15'd9512, 15'd12539, 15'd15446, 15'd18204,
        15'd20787, 15'd23170, 15'd25329, 15'd27245, 15'd28898, 15'd30273,
        15'd31356, 15'd32137, 15'd32609, 15'd32767
    };

    typedef struct packed {
        logic        cmd;
        logic [3:0]  idx;
        logic [15:0] level;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } q_ent_t;

    typedef struct packed {
        logic [15:0] energy;
        logic [15:0] bump_gain;
        logic [15:0] phase_a;
        logic [15:0] phase_b;
    } cfg_t;

    typedef struct packed {
        logic [14:0] a;
        logic [11:0] diff;
        logic [9:0]  frac;
        logic        neg;
    } sine_pt_t;

    // Table point, slope and fraction for a 16-bit phase (65536 = one turn).
    function automatic sine_pt_t sine_pt(input logic [15:0] p);
        logic [14:0] u;
        logic [4:0]  idx;
        logic [4:0]  idx_hi;
        sine_pt_t    r;
        u = p[14] ? (15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
        idx = u[14:10];
        idx_hi = (idx == 5'd16) ? idx : idx + 5'd1;
        r.a = QUARTER_SINE[idx];
        r.diff = 12'(QUARTER_SINE[idx_hi] - QUARTER_SINE[idx]);
        r.frac = u[9:0];
        r.neg = p[15];
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/sphere_vertex_bulge_deform.sv]
// Sphere vertex bulge deformer: takes load and vertex requests on a stream port and
// returns one displaced position per vertex. A load (tuser low) writes one band's level
// and bump centre; a vertex (tuser high) is summed against every band, rippled and scaled.
// A load is written to the band table in the back end's load state. A vertex leaves the
// queue, takes a dot product and threshold test against each band, adds a falloff and
// level product for each band above the 0.3 threshold, then is rippled and scaled, all
// on the single shared 28x28 multiplier. A two-request queue lets the front end keep
// taking requests while the back end works, and the output register holds a finished
// position while the next request proceeds; a back end that finishes while that register
// is still full waits on its last step. Band tables clear at reset through per-entry
// valid bits; there is no clearing pass.
// Depends on svbd_pkg, svbd_front, svbd_queue, svbd_back, svbd_ram.
`timescale 1ns / 1ps
`default_nettype none
module sphere_vertex_bulge_deform #(
    parameter int BANDS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // band_index, level, dir_x, dir_y, dir_z, pad
    input  wire logic        s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // pos_x, pos_y, pos_z
);
    svbd_pkg::cfg_t   cfg_reg, cfg_next;
    svbd_pkg::q_ent_t in_ent, push_data, pop_data;
    logic q_full, q_push, q_pop, q_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                svbd_pkg::CFG_ENERGY:    cfg_next.energy    = cfg_data;
                svbd_pkg::CFG_BUMP_GAIN: cfg_next.bump_gain = cfg_data;
                svbd_pkg::CFG_PHASE_A:   cfg_next.phase_a   = cfg_data;
                svbd_pkg::CFG_PHASE_B:   cfg_next.phase_b   = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Unpack the request fields.
    assign in_ent.cmd   = s_tuser;
    assign in_ent.idx   = s_tdata[3:0];
    assign in_ent.level = s_tdata[19:4];
    assign in_ent.x     = s_tdata[35:20];
    assign in_ent.y     = s_tdata[51:36];
    assign in_ent.z     = s_tdata[67:52];

    svbd_front #(.BANDS(BANDS)) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_ent   (in_ent),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    svbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    svbd_back #(.BANDS(BANDS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );
endmodule
`default_nettype wire

[rtl/svbd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module svbd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/svbd_front.sv]
// Front end: takes input requests, drops loads aimed past the table, queues the rest.
// Depends on svbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svbd_front #(
    parameter int BANDS = 16
) (
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire svbd_pkg::q_ent_t in_ent,
    input  wire logic            q_full,
    output logic                 q_push,
    output svbd_pkg::q_ent_t     q_data
);
    logic idx_ok;

    assign idx_ok   = ({28'd0, in_ent.idx} < 32'(BANDS));
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && ((in_ent.cmd == svbd_pkg::CMD_VERTEX) || idx_ok);
    assign q_data   = in_ent;
endmodule
`default_nettype wire

[rtl/svbd_queue.sv]
// Two-entry request queue between front end and back end.
// Depends on svbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svbd_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire svbd_pkg::q_ent_t push_data,
    output logic                  full,
    input  wire logic             pop,
    output svbd_pkg::q_ent_t      pop_data,
    output logic                  empty
);
    svbd_pkg::q_ent_t slot_reg [2];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg ^ push;
        rd_next  = rd_reg ^ pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

[rtl/svbd_back.sv]
// Back end: table loads, band sweep and ripple/scale sequence on one shared multiplier.
// Depends on svbd_pkg and svbd_ram.
`timescale 1ns / 1ps
`default_nettype none
module svbd_back #(
    parameter int BANDS = 16,
    localparam int AW = (BANDS > 1) ? $clog2(BANDS) : 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire svbd_pkg::cfg_t   cfg,
    input  wire logic             q_empty,
    input  wire svbd_pkg::q_ent_t q_data,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [47:0]           out_data
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_BAND = 4'b0100,
        S_TAIL = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0]    step_reg, step_next;
    logic [AW-1:0] band_reg, band_next;
    logic [BANDS-1:0] vmap_reg, vmap_next;
    logic          vld_reg, vld_next;
    svbd_pkg::q_ent_t ent_reg, ent_next;
    logic signed [34:0] acc_reg, acc_next;
    logic [32:0]   bulge_reg, bulge_next;
    logic signed [55:0] prod_reg;
    logic [15:0]   ps_reg, ps_next, pc_reg, pc_next;
    logic signed [16:0] sv_reg, sv_next, cv_reg, cv_next;
    logic signed [12:0] wob_reg, wob_next;
    logic [15:0]   mult_reg, mult_next, r_reg, r_next;
    logic [15:0]   px_reg, px_next, py_reg, py_next;
    logic          ov_reg, ov_next;
    logic [47:0]   od_reg, od_next;

    logic signed [27:0] mul_a, mul_b;
    logic signed [55:0] prod;
    logic [63:0]   rdata;
    logic          ram_we, ram_re;
    logic [15:0]   c_x, c_y, c_z, lvl;
    logic signed [34:0] dsum, ediff;
    svbd_pkg::sine_pt_t sp_s, sp_c;
    logic [15:0]   sval_s, sval_c;
    logic signed [18:0] msum;
    logic          last_band;

    svbd_ram #(.WIDTH(64), .DEPTH(BANDS)) u_tab (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(ent_reg.idx)),
        .wdata ({ent_reg.level, ent_reg.z, ent_reg.y, ent_reg.x}),
        .re    (ram_re),
        .raddr (band_reg),
        .rdata (rdata)
    );

    // Entries never loaded since reset read as zero.
    assign c_x = vld_reg ? rdata[15:0]  : 16'd0;
    assign c_y = vld_reg ? rdata[31:16] : 16'd0;
    assign c_z = vld_reg ? rdata[47:32] : 16'd0;
    assign lvl = vld_reg ? rdata[63:48] : 16'd0;

    assign ram_we    = (state_reg == S_LOAD);
    assign ram_re    = (state_reg == S_BAND) && (step_reg == 5'd0);
    assign last_band = (band_reg == AW'(BANDS - 1));
    assign dsum      = acc_reg + prod_reg[34:0];
    assign ediff     = acc_reg - svbd_pkg::DOT_THRESH;
    assign sp_s      = svbd_pkg::sine_pt(ps_reg);
    assign sp_c      = svbd_pkg::sine_pt(pc_reg);
    assign sval_s    = {1'b0, sp_s.a} + {4'd0, prod_reg[21:10]};
    assign sval_c    = {1'b0, sp_c.a} + {4'd0, prod_reg[21:10]};
    assign msum      = 19'sd32768 + 19'(prod_reg[34:14]) + 19'(wob_reg);
    assign prod      = mul_a * mul_b;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_BAND:
            begin
                case (step_reg)
                    5'd1:
                    begin
                        mul_a = 28'(ent_reg.x);
                        mul_b = 28'(signed'(c_x));
                    end
                    5'd2:
                    begin
                        mul_a = 28'(ent_reg.y);
                        mul_b = 28'(signed'(c_y));
                    end
                    5'd3:
                    begin
                        mul_a = 28'(ent_reg.z);
                        mul_b = 28'(signed'(c_z));
                    end
                    5'd5:
                    begin
                        mul_a = {7'd0, ediff[34:14]};
                        mul_b = {12'd0, svbd_pkg::INV_07_Q15};
                    end
                    5'd6:
                    begin
                        mul_a = prod_reg[41:14];
                        mul_b = prod_reg[41:14];
                    end
                    5'd7:
                    begin
                        mul_a = {12'd0, lvl};
                        mul_b = prod_reg[42:15];
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_TAIL:
            begin
                case (step_reg)
                    5'd0:
                    begin
                        mul_a = 28'(ent_reg.x);
                        mul_b = {14'd0, svbd_pkg::CS_X};
                    end
                    5'd1:
                    begin
                        mul_a = 28'(ent_reg.y);
                        mul_b = {14'd0, svbd_pkg::CS_Y};
                    end
                    5'd2:
                    begin
                        mul_a = 28'(ent_reg.z);
                        mul_b = {14'd0, svbd_pkg::CS_Z};
                    end
                    5'd4:
                    begin
                        mul_a = {16'd0, sp_s.diff};
                        mul_b = {18'd0, sp_s.frac};
                    end
                    5'd5:
                    begin
                        mul_a = {16'd0, sp_c.diff};
                        mul_b = {18'd0, sp_c.frac};
                    end
                    5'd7:
                    begin
                        mul_a = 28'(sv_reg);
                        mul_b = 28'(cv_reg);
                    end
                    5'd8:
                    begin
                        mul_a = 28'(signed'(prod_reg[33:15]));
                        mul_b = {16'd0, svbd_pkg::WOB_Q15};
                    end
                    5'd9:
                    begin
                        mul_a = {12'd0, cfg.bump_gain};
                        mul_b = {11'd0, bulge_reg[16:0]};
                    end
                    5'd10:
                    begin
                        mul_a = {10'd0, prod_reg[32:15]};
                        mul_b = {13'd0, svbd_pkg::K14_Q14};
                    end
                    5'd11:
                    begin
                        mul_a = {18'd0, svbd_pkg::BREATH_Q15};
                        mul_b = {12'd0, cfg.energy};
                    end
                    5'd12:
                    begin
                        mul_a = {12'd0, {2'd0, svbd_pkg::BASE_Q15} + prod_reg[30:15]};
                        mul_b = {12'd0, mult_reg};
                    end
                    5'd14:
                    begin
                        mul_a = 28'(ent_reg.x);
                        mul_b = {12'd0, r_reg};
                    end
                    5'd15:
                    begin
                        mul_a = 28'(ent_reg.y);
                        mul_b = {12'd0, r_reg};
                    end
                    // z product is held while the result waits on the output
                    5'd16, 5'd17:
                    begin
                        mul_a = 28'(ent_reg.z);
                        mul_b = {12'd0, r_reg};
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        band_next  = band_reg;
        vmap_next  = vmap_reg;
        vld_next   = vld_reg;
        ent_next   = ent_reg;
        acc_next   = acc_reg;
        bulge_next = bulge_reg;
        ps_next    = ps_reg;
        pc_next    = pc_reg;
        sv_next    = sv_reg;
        cv_next    = cv_reg;
        wob_next   = wob_reg;
        mult_next  = mult_reg;
        r_next     = r_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    ent_next   = q_data;
                    band_next  = '0;
                    step_next  = 5'd0;
                    bulge_next = '0;
                    state_next = (q_data.cmd == svbd_pkg::CMD_VERTEX) ? S_BAND : S_LOAD;
                end
            end
            S_LOAD:
            begin
                vmap_next[AW'(ent_reg.idx)] = 1'b1;
                state_next = S_IDLE;
            end
            S_BAND:
            begin
                step_next = step_reg + 5'd1;
                case (step_reg)
                    5'd0: vld_next = vmap_reg[band_reg];
                    5'd2: acc_next = prod_reg[34:0];
                    5'd3: acc_next = dsum;
                    5'd4: acc_next = dsum;
                    5'd5:
                    begin
                        if (acc_reg <= svbd_pkg::DOT_THRESH)
                        begin
                            step_next = 5'd0;
                            band_next = band_reg + AW'(1);
                            if (last_band)
                            begin
                                state_next = S_TAIL;
                            end
                        end
                    end
                    5'd8:
                    begin
                        bulge_next = bulge_reg + prod_reg[47:15];
                        step_next  = 5'd0;
                        band_next  = band_reg + AW'(1);
                        if (last_band)
                        begin
                            state_next = S_TAIL;
                        end
                    end
                    default: ;
                endcase
            end
            S_TAIL:
            begin
                step_next = step_reg + 5'd1;
                case (step_reg)
                    5'd0:
                    begin
                        if (bulge_reg > {17'd0, svbd_pkg::ONE_Q15})
                        begin
                            bulge_next = {17'd0, svbd_pkg::ONE_Q15};
                        end
                    end
                    5'd1: acc_next = prod_reg[34:0];
                    5'd2: ps_next = dsum[27:12] + cfg.phase_a;
                    5'd3: pc_next = prod_reg[27:12] - cfg.phase_b + svbd_pkg::QUARTER;
                    5'd5: sv_next = sp_s.neg ? -17'(sval_s) : 17'(sval_s);
                    5'd6: cv_next = sp_c.neg ? -17'(sval_c) : 17'(sval_c);
                    5'd9: wob_next = prod_reg[27:15];
                    5'd11:
                    begin
                        if (msum > 19'(svbd_pkg::CAP_MULT))
                        begin
                            mult_next = svbd_pkg::CAP_MULT;
                        end
                        else if (msum < 0)
                        begin
                            mult_next = 16'd0;
                        end
                        else
                        begin
                            mult_next = msum[15:0];
                        end
                    end
                    5'd13: r_next = prod_reg[30:15];
                    5'd15: px_next = prod_reg[30:15];
                    5'd16: py_next = prod_reg[30:15];
                    5'd17:
                    begin
                        if (!ov_reg || out_ready)
                        begin
                            ov_next    = 1'b1;
                            od_next    = {prod_reg[30:15], py_reg, px_reg};
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            step_next = step_reg;
                        end
                    end
                    default: ;
                endcase
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 5'd0;
            band_reg  <= '0;
            vmap_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            band_reg  <= band_next;
            vmap_reg  <= vmap_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vld_reg   <= vld_next;
        ent_reg   <= ent_next;
        acc_reg   <= acc_next;
        bulge_reg <= bulge_next;
        prod_reg  <= prod;
        ps_reg    <= ps_next;
        pc_reg    <= pc_next;
        sv_reg    <= sv_next;
        cv_reg    <= cv_next;
        wob_reg   <= wob_next;
        mult_reg  <= mult_next;
        r_reg     <= r_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        od_reg    <= od_next;
    end
endmodule
`default_nettype wire

[rtl/svbd_checker.sv]
// Port-level checker for the bulge deformer, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module svbd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);
    logic [2:0] pend_reg, pend_next;

    // Vertex requests accepted but not yet delivered.
    always_comb
    begin
        pend_next = pend_reg + {2'd0, s_tvalid && s_tready && s_tuser}
                             - {2'd0, m_tvalid && m_tready};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `SVBD_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `SVBD_ASSERT_NOW(a_no_orphan, clk, rst_n, m_tvalid, pend_reg != 3'd0, "result with no vertex pending")
    `SVBD_ASSERT_NOW(a_depth, clk, rst_n, 1'b1, pend_reg <= 3'd4, "more vertices in flight than storage allows")
endmodule

bind sphere_vertex_bulge_deform svbd_checker u_chk (.*);
`default_nettype wire

[dv/sphere_vertex_bulge_deform_test.sv]
// Self-checking testbench for sphere_vertex_bulge_deform: band loads and vertex requests
// on the stream port, positions predicted in-bench and compared field by field.
// Depends on svbd_pkg and the deformer RTL.
`timescale 1ns / 1ps
`default_nettype none
module sphere_vertex_bulge_deform_test;

    // Fixed-point constants of the deformer datapath
    localparam longint DOT_T     = 80530637;   // 0.3 in Q28
    localparam longint INV_07    = 46811;      // 1/0.7 in Q15
    localparam longint RIPPLE_K  = 2294;       // 0.07 in Q15
    localparam longint BULGE_K   = 22938;      // 1.4 in Q14
    localparam longint MULT_CAP  = 52429;      // 1.6 in Q15
    localparam longint UNITY     = 32768;
    localparam longint RAD_BASE  = 14746;      // 0.45 in Q15
    localparam longint RAD_BREATH = 983;       // 0.03 in Q15
    localparam longint KX = 9127, KY = 5737, KZ = 7823;
    localparam int     NBANDS    = 16;
    localparam int     DRAIN_CYCLES = 200;
    localparam int     STALL_LIMIT  = 5000;

    localparam int QSINE [17] = '{0, 3212, 6393, 9512, 12539, 15446, 18204, 20787,
        23170, 25329, 27245, 28898, 30273, 31356, 32137, 32609, 32767};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;   // band_index, level, dir_x, dir_y, dir_z, pad
    logic        s_tuser = 1'b0; // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // pos_x, pos_y, pos_z

    sphere_vertex_bulge_deform dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow of the block's registers and band tables
    logic [15:0] energy_q, gain_q, phase_a_q, phase_b_q;
    logic [15:0] lvl_shadow [NBANDS];
    logic signed [15:0] band_cx [NBANDS], band_cy [NBANDS], band_cz [NBANDS];

    logic [47:0] pending_pos [$];
    int          mismatches = 0;
    int          tx_idle = 0;
    int          rx_idle = 0;
    int          quiet_cycles = 0;

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d want %0d at %0t",
                 what, $signed(got), $signed(want), $realtime);
        mismatches++;
    endtask

    function automatic longint sine_of(logic [15:0] p);
        int     u;
        int     idx;
        longint val;
        u = p[13:0];
        if (p[14])
            u = 16384 - u;
        idx = u >> 10;
        if (idx >= 16)
            val = QSINE[16];
        else
            val = QSINE[idx] + (((longint'(QSINE[idx + 1] - QSINE[idx])) * (u & 1023)) >>> 10);
        return p[15] ? -val : val;
    endfunction

    // Displaced position for one vertex request against the current tables
    function automatic logic [47:0] deformed_position(svbd_pkg::q_ent_t v);
        longint x, y, z, d, e, f, f2, bulge, s, c, wob, bb, mult, base, r;
        logic [15:0] ps, pc;
        x = longint'($signed(v.x));
        y = longint'($signed(v.y));
        z = longint'($signed(v.z));
        bulge = 0;
        for (int b = 0; b < NBANDS; b++)
        begin
            d = x * band_cx[b] + y * band_cy[b] + z * band_cz[b];
            if (d > DOT_T)
            begin
                e = (d - DOT_T) >>> 14;
                f = (e * INV_07) >>> 14;
                f2 = (f * f) >>> 15;
                bulge += (longint'(lvl_shadow[b]) * f2) >>> 15;
            end
        end
        if (bulge > UNITY)
            bulge = UNITY;
        ps = 16'(((x * KX + y * KY) >>> 12) + longint'(phase_a_q));
        pc = 16'(((z * KZ) >>> 12) - longint'(phase_b_q));
        s = sine_of(ps);
        c = sine_of(pc + 16'd16384);
        wob = (((s * c) >>> 15) * RIPPLE_K) >>> 15;
        bb = (longint'(gain_q) * bulge) >>> 15;
        mult = UNITY + ((bb * BULGE_K) >>> 14) + wob;
        if (mult > MULT_CAP)
            mult = MULT_CAP;
        if (mult < 0)
            mult = 0;
        base = RAD_BASE + ((RAD_BREATH * longint'(energy_q)) >>> 15);
        r = (base * mult) >>> 15;
        return {16'((z * r) >>> 15), 16'((y * r) >>> 15), 16'((x * r) >>> 15)};
    endfunction

    // Receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle);

    // Checks results, then records accepted requests; watchdog on handshake silence
    always @(posedge clk)
    begin
        svbd_pkg::q_ent_t req;
        logic [47:0]      want;
        if (m_tvalid && m_tready)
        begin
            if (pending_pos.size() == 0)
            begin
                report_mismatch("unexpected pos_x", m_tdata[15:0], 16'd0);
            end
            else
            begin
                want = pending_pos.pop_front();
                if (m_tdata[15:0] !== want[15:0])
                    report_mismatch("pos_x", m_tdata[15:0], want[15:0]);
                if (m_tdata[31:16] !== want[31:16])
                    report_mismatch("pos_y", m_tdata[31:16], want[31:16]);
                if (m_tdata[47:32] !== want[47:32])
                    report_mismatch("pos_z", m_tdata[47:32], want[47:32]);
            end
        end
        if (s_tvalid && s_tready)
        begin
            req.cmd   = s_tuser;
            req.idx   = s_tdata[3:0];
            req.level = s_tdata[19:4];
            req.x     = s_tdata[35:20];
            req.y     = s_tdata[51:36];
            req.z     = s_tdata[67:52];
            if (req.cmd == svbd_pkg::CMD_VERTEX)
                pending_pos.push_back(deformed_position(req));
            else
            begin
                // 4-bit index always fits the 16-entry table
                lvl_shadow[req.idx] = req.level;
                band_cx[req.idx] = req.x;
                band_cy[req.idx] = req.y;
                band_cz[req.idx] = req.z;
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Drives one request; tvalid is left high so back-to-back requests need no gap
    task automatic send_request(svbd_pkg::q_ent_t q);
        while ($urandom_range(99) < tx_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= q.cmd;
        s_tdata  <= {4'd0, q.z, q.y, q.x, q.level, q.idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drops tvalid, waits for every expected position, then lets loads settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_pos.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [15:0] value);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (addr)
            svbd_pkg::CFG_ENERGY:    energy_q  = value;
            svbd_pkg::CFG_BUMP_GAIN: gain_q    = value;
            svbd_pkg::CFG_PHASE_A:   phase_a_q = value;
            svbd_pkg::CFG_PHASE_B:   phase_b_q = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic svbd_pkg::q_ent_t make_req(logic cmd, logic [3:0] idx,
                                                  logic [15:0] level, logic [15:0] x,
                                                  logic [15:0] y, logic [15:0] z);
        svbd_pkg::q_ent_t q;
        q.cmd = cmd; q.idx = idx; q.level = level;
        q.x = x; q.y = y; q.z = z;
        return q;
    endfunction

    // Roughly unit direction in Q1.14, length 0.9..1.0
    function automatic svbd_pkg::q_ent_t unit_dir(svbd_pkg::q_ent_t q);
        real ax, ay, az, len, k;
        ax = real'($urandom_range(2000)) - 1000.0;
        ay = real'($urandom_range(2000)) - 1000.0;
        az = real'($urandom_range(2000)) - 1000.0;
        len = $sqrt(ax * ax + ay * ay + az * az) + 1.0;
        k = 16384.0 * (0.9 + 0.1 * real'($urandom_range(100)) / 100.0) / len;
        q.x = 16'($rtoi(ax * k));
        q.y = 16'($rtoi(ay * k));
        q.z = 16'($rtoi(az * k));
        return q;
    endfunction

    // Empty tables after reset: radius and ripple only
    task automatic test_cleared_tables();
        send_request(make_req(svbd_pkg::CMD_VERTEX, 4'd0, 16'd0, 16'sd16384, 16'sd0, 16'sd0));
        send_request(make_req(svbd_pkg::CMD_VERTEX, 4'd15, 16'hFFFF, 16'sd0, -16'sd16384,
                              16'sd0));
        send_request(make_req(svbd_pkg::CMD_VERTEX, 4'd7, 16'd0, 16'sd0, 16'sd0, 16'sd16384));
    endtask

    // Field extremes, full bulge, oversized dot and the multiplier cap
    task automatic test_extremes();
        wait_idle();
        write_reg(svbd_pkg::CFG_ENERGY, 16'd32768);
        write_reg(svbd_pkg::CFG_BUMP_GAIN, 16'd32768);
        write_reg(svbd_pkg::CFG_PHASE_A, 16'hFFFF);
        write_reg(svbd_pkg::CFG_PHASE_B, 16'hFFFF);
        send_request(make_req(svbd_pkg::CMD_LOAD, 4'd0, 16'd32768, 16'sd16384, 16'sd0, 16'sd0));
        send_request(make_req(svbd_pkg::CMD_LOAD, 4'd15, 16'hFFFF, -16'sd16384, -16'sd16384,
                              16'sd0));
        send_request(make_req(svbd_pkg::CMD_LOAD, 4'd5, 16'd32768, 16'sd0, 16'sd0,
                              -16'sd16384));
        send_request(make_req(svbd_pkg::CMD_LOAD, 4'd10, 16'd12000, 16'sh7FFF, 16'sh7FFF,
                              16'sh7FFF));
        send_request(make_req(svbd_pkg::CMD_VERTEX, 4'd0, 16'd0, 16'sd16384, 16'sd0, 16'sd0));
        send_request(make_req(svbd_pkg::CMD_VERTEX, 4'd0, 16'd0, -16'sd16384, -16'sd16384,
                              16'sd0));
        send_request(make_req(svbd_pkg::CMD_VERTEX, 4'd0, 16'd0, 16'sd0, 16'sd0, -16'sd16384));
        send_request(make_req(svbd_pkg::CMD_VERTEX, 4'd0, 16'd0, 16'sh8000, 16'sh8000,
                              16'sh8000));
        send_request(make_req(svbd_pkg::CMD_VERTEX, 4'd0, 16'd0, 16'sh7FFF, 16'sh7FFF,
                              16'sh7FFF));
        send_request(make_req(svbd_pkg::CMD_VERTEX, 4'd0, 16'd0, 16'sd5000, 16'sd5000, 16'sd0));
        // overwrite a band with zero level: its bulge vanishes
        send_request(make_req(svbd_pkg::CMD_LOAD, 4'd0, 16'd0, 16'sd16384, 16'sd0, 16'sd0));
        send_request(make_req(svbd_pkg::CMD_VERTEX, 4'd0, 16'd0, 16'sd16384, 16'sd0, 16'sd0));
        wait_idle();
        write_reg(svbd_pkg::CFG_ENERGY, 16'hFFFF);
        write_reg(svbd_pkg::CFG_BUMP_GAIN, 16'd0);
        write_reg(svbd_pkg::CFG_PHASE_A, 16'd0);
        write_reg(svbd_pkg::CFG_PHASE_B, 16'd16384);
        send_request(make_req(svbd_pkg::CMD_VERTEX, 4'd0, 16'd0, 16'sd0, -16'sd16384, 16'sd0));
        send_request(make_req(svbd_pkg::CMD_VERTEX, 4'd0, 16'd0, 16'sd11585, 16'sd0,
                              16'sd11585));
    endtask

    // Mostly unit loads and vertices near stored centres, some raw noise
    task automatic test_random(int count);
        svbd_pkg::q_ent_t q;
        int               pick;
        int               b;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            q = make_req(svbd_pkg::CMD_VERTEX, 4'($urandom), 16'($urandom), '0, '0, '0);
            if (pick < 25)
            begin
                q = unit_dir(q);
                q.cmd = svbd_pkg::CMD_LOAD;
                if ($urandom_range(3) != 0)
                    q.level = 16'($urandom_range(32768));
            end
            else if (pick < 55)
                q = unit_dir(q);
            else if (pick < 88)
            begin
                b = $urandom_range(NBANDS - 1);
                q.x = band_cx[b] + 16'($signed($urandom_range(6000)) - 3000);
                q.y = band_cy[b] + 16'($signed($urandom_range(6000)) - 3000);
                q.z = band_cz[b] + 16'($signed($urandom_range(6000)) - 3000);
            end
            else
            begin
                q.cmd = 1'($urandom);
                q.x = 16'($urandom);
                q.y = 16'($urandom);
                q.z = 16'($urandom);
            end
            send_request(q);
            // occasionally hold off until the block has emptied
            if ($urandom_range(99) == 0)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_pos.size() != 0)
                    @(posedge clk);
            end
        end
    endtask

    task automatic random_settings();
        wait_idle();
        write_reg(svbd_pkg::CFG_ENERGY, 16'($urandom_range(32768)));
        write_reg(svbd_pkg::CFG_BUMP_GAIN, 16'($urandom_range(32768)));
        write_reg(svbd_pkg::CFG_PHASE_A, 16'($urandom));
        write_reg(svbd_pkg::CFG_PHASE_B, 16'($urandom));
    endtask

    initial
    begin
        energy_q = '0; gain_q = '0; phase_a_q = '0; phase_b_q = '0;
        for (int b = 0; b < NBANDS; b++)
        begin
            lvl_shadow[b] = '0;
            band_cx[b] = '0; band_cy[b] = '0; band_cz[b] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle = 16; rx_idle = 49;
        test_cleared_tables();
        test_extremes();
        random_settings();
        test_random(150);
        random_settings();
        test_random(150);
        tx_idle = 49; rx_idle = 16;
        random_settings();
        test_random(150);
        random_settings();
        test_random(150);
        tx_idle = 0; rx_idle = 0;
        random_settings();
        test_random(150);
        wait_idle();
        write_reg(svbd_pkg::CFG_ENERGY, 16'd0);
        write_reg(svbd_pkg::CFG_BUMP_GAIN, 16'd32768);
        test_random(130);
        wait_idle();

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire

[sphere_vertex_bulge_deform.f]
+incdir+rtl
rtl/svbd_pkg.sv
rtl/svbd_ram.sv
rtl/svbd_front.sv
rtl/svbd_queue.sv
rtl/svbd_back.sv
rtl/sphere_vertex_bulge_deform.sv
rtl/svbd_checker.sv
dv/sphere_vertex_bulge_deform_test.sv
